FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/pil_pkg.sv
// ----------------------------------------------------------------------------
// pil_pkg
// shared constants, codes and types of the positional insert list
// ----------------------------------------------------------------------------
package pil_pkg;

  // list size and field widths
  localparam int CAPACITY   = 256;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 8;
  localparam int OUT_CNT_W  = 9;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // read reduction tree shape
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_INSERT     = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             shift_en;
    logic [CMP_W-1:0] where;
    logic [VAL_W-1:0] value;
    logic [CMP_W-1:0] rd_pos;
  } cell_ctl_t;

endpackage

FILE: rtl/core/pil_cell.sv
// ----------------------------------------------------------------------------
// pil_cell
// one list entry: holds, takes its left neighbor or takes the new value
// ----------------------------------------------------------------------------
module pil_cell
  import pil_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CMP_W-1:0] my_index,
  input  logic [VAL_W-1:0] prev_value,
  output logic [VAL_W-1:0] value,
  output logic [VAL_W-1:0] rd_tap
);

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;

  // entries past the insert point move one place back
  always_comb begin
    value_nxt = value_r;
    if (ctl.shift_en) begin
      if (my_index > ctl.where) begin
        value_nxt = prev_value;
      end else if (my_index == ctl.where) begin
        value_nxt = ctl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // drive the read tap only when addressed
  assign value  = value_r;
  assign rd_tap = (my_index == ctl.rd_pos) ? value_r : '0;

endmodule

FILE: rtl/core/pil_rd_tree.sv
// ----------------------------------------------------------------------------
// pil_rd_tree
// two-level or-tree over the cell read taps, first level registered
// ----------------------------------------------------------------------------
module pil_rd_tree
  import pil_pkg::*;
(
  input  logic                            clk,
  input  logic                            load,
  input  logic [CAPACITY-1:0][VAL_W-1:0]  taps,
  output logic [VAL_W-1:0]                rd_data
);

  logic [NUM_GROUPS-1:0][VAL_W-1:0] group_r;
  logic [NUM_GROUPS-1:0][VAL_W-1:0] group_nxt;

  // first level: or within each group of cells
  always_comb begin
    group_nxt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          group_nxt[g] = group_nxt[g] | taps[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      group_r <= group_nxt;
    end
  end

  // second level: or across groups
  always_comb begin
    rd_data = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      rd_data = rd_data | group_r[g];
    end
  end

endmodule

FILE: rtl/core/positional_insert_list.sv
// ----------------------------------------------------------------------------
// positional_insert_list
// bounded ordered list of signed 32-bit values built as a chain of cells
// ----------------------------------------------------------------------------
// Usage: one command per input transfer (push front, push back, insert at
// position, read at position); each command gives exactly one result
// transfer with the read value, a status and the count after the command.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// Order: a transfer loads the pending registers and the registered first
// level of the read or-tree; out_valid rises once the result moves on into
// the output register. Inserts shift the whole cell chain in the transfer
// cycle. A new command is not taken until the pending result has moved
// into the output register, so only one command is in flight at a time.
// Stall: while the output register holds an untaken result and the
// receiver stalls, in_stall stays high; nothing is lost or repeated.
// Reset: the count and all valid flags clear; entry contents are not
// cleared and are never seen since reads stop at the count.
// ----------------------------------------------------------------------------
module positional_insert_list
  import pil_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [1:0]              out_status,
  output logic [OUT_CNT_W-1:0]    out_count
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 pend_r;
  logic                 pend_rd_ok_r;
  status_t              pend_status_r;
  logic [OUT_CNT_W-1:0] pend_count_r;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_read_value_r;
  status_t              out_status_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic                 in_xfer;
  logic                 out_load;
  cmd_t                 cmd;
  logic                 full;
  logic                 store;
  logic                 rd_ok;
  status_t              status;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     where;
  cell_ctl_t            ctl;
  logic [CAPACITY-1:0][VAL_W-1:0] cell_value;
  logic [CAPACITY-1:0][VAL_W-1:0] cell_tap;
  logic [VAL_W-1:0]     rd_data;

  // handshake: one command in flight, output register frees the receiver side
  assign in_stall = pend_r | (out_valid_r & out_stall);
  assign in_xfer  = in_valid & ~in_stall;
  assign out_load = pend_r & (~out_valid_r | ~out_stall);

  // command decode and status
  assign cmd     = cmd_t'(in_command);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r >= CAP_CNT);

  always_comb begin
    store  = 1'b0;
    rd_ok  = 1'b0;
    status = ST_OK;
    where  = pos_ext;
    unique case (cmd)
      CMD_READ: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        where = '0;
        if (full) status = ST_FULL;
        else store = 1'b1;
      end
      CMD_PUSH_BACK: begin
        where = cnt_ext;
        if (full) status = ST_FULL;
        else store = 1'b1;
      end
      default: begin
        where = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
        if (full) status = ST_FULL;
        else store = 1'b1;
      end
    endcase
  end

  assign count_nxt = (in_xfer && store) ? count_r + CNT_W'(1) : count_r;

  // control broadcast to the chain
  always_comb begin
    ctl.shift_en = in_xfer & store;
    ctl.where    = where;
    ctl.value    = in_value;
    ctl.rd_pos   = pos_ext;
  end

  // chain of cells, each fed by its left neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] prev;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = cell_value[i-1];
    end
    pil_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .my_index   (CMP_W'(i)),
      .prev_value (prev),
      .value      (cell_value[i]),
      .rd_tap     (cell_tap[i])
    );
  end

  pil_rd_tree u_rd_tree (
    .clk     (clk),
    .load    (in_xfer),
    .taps    (cell_tap),
    .rd_data (rd_data)
  );

  // count and pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_xfer) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_rd_ok_r  <= rd_ok;
      pend_status_r <= status;
      pend_count_r  <= OUT_CNT_W'(count_nxt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_read_value_r <= pend_rd_ok_r ? rd_data : '0;
      out_status_r     <= pend_status_r;
      out_count_r      <= pend_count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

FILE: rtl/core/pil_checker.sv
// ----------------------------------------------------------------------------
// pil_checker
// port-level checks of the positional insert list, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pil_checker
  import pil_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_read_value,
  input logic [1:0]              out_status,
  input logic [OUT_CNT_W-1:0]    out_count
);

  logic                           res_err;
  logic                           res_empty;
  logic                           res_full;
  logic [VAL_W+OUT_CNT_W+1:0]     res_payload;

  // result classes and the full result payload
  assign res_err     = out_valid && (out_status != ST_OK);
  assign res_empty   = out_valid && (out_status == ST_EMPTY);
  assign res_full    = out_valid && (out_status == ST_FULL);
  assign res_payload = {out_read_value, out_status, out_count};

  // failed commands never carry a read value
  `ASSERT_IMPLY(a_err_no_value, clk, rst_n, res_err, out_read_value == '0)

  // an empty-list read reports a zero count
  `ASSERT_IMPLY(a_empty_count, clk, rst_n, res_empty, out_count == '0)

  // a dropped store reports a full list
  `ASSERT_IMPLY(a_full_count, clk, rst_n, res_full, out_count == OUT_CNT_W'(CAPACITY))

  // only one command in flight: the cycle after a transfer the input is held
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(res_payload))

endmodule

bind positional_insert_list pil_checker u_pil_checker (.*);
